// ===== hdl/cdq_pkg.sv =====
// Shared types and constants of the circular deque.
package cdq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int WORD_W        = 32;
  localparam int CFG_W         = 7;
  localparam int CAP_RESET     = 64;
  localparam int PICK_GRP      = 8;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_REAR  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } cdq_mode_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } cdq_status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_IN,
    CELL_SHIFT_OUT,
    CELL_APPEND,
    CELL_DROP_REAR,
    CELL_CLEAR
  } cdq_cell_op_e;

  typedef enum logic {
    S_IDLE,
    S_REAR
  } cdq_state_e;

  typedef struct packed {
    cdq_cell_op_e        op;
    logic [WORD_W-1:0]   value;
  } cdq_cell_cmd_t;

endpackage

// ===== hdl/cdq_req_if.sv =====
// Request channel: mode and push value.
interface cdq_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        mode;
  logic signed [cdq_pkg::WORD_W-1:0] push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

// ===== hdl/cdq_rsp_if.sv =====
// Response channel: popped value and status.
interface cdq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [cdq_pkg::WORD_W-1:0] pop_value;
  logic [1:0]                        status;

  modport source (output valid, output pop_value, output status, input ready);
  modport sink   (input valid, input pop_value, input status, output ready);
endinterface

// ===== hdl/cdq_cfg_if.sv =====
// Configuration write channel: capacity in use.
interface cdq_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [cdq_pkg::CFG_W-1:0]  capacity_in_use;

  modport source (output valid, output capacity_in_use, input ready);
  modport sink   (input valid, input capacity_in_use, output ready);
endinterface

// ===== hdl/cdq_cell.sv =====
// One deque cell: a data word and a valid bit, shifting with its neighbors.
module cdq_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cdq_pkg::cdq_cell_cmd_t        cmd_i,
  input  logic                          left_valid_i,
  input  logic [cdq_pkg::WORD_W-1:0]    left_data_i,
  input  logic                          right_valid_i,
  input  logic [cdq_pkg::WORD_W-1:0]    right_data_i,
  output logic                          valid_o,
  output logic                          last_o,
  output logic [cdq_pkg::WORD_W-1:0]    data_o
);

  logic                       valid_q, valid_d;
  logic [cdq_pkg::WORD_W-1:0] data_q, data_d;

  // Rear entry: held here, nothing held to the right.
  assign last_o  = valid_q && !right_valid_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    case (cmd_i.op)
      cdq_pkg::CELL_SHIFT_IN: begin
        valid_d = left_valid_i;
        data_d  = left_data_i;
      end
      cdq_pkg::CELL_SHIFT_OUT: begin
        valid_d = right_valid_i;
        data_d  = right_data_i;
      end
      cdq_pkg::CELL_APPEND: begin
        if (!valid_q && left_valid_i) begin
          valid_d = 1'b1;
          data_d  = cmd_i.value;
        end
      end
      cdq_pkg::CELL_DROP_REAR: begin
        if (last_o) valid_d = 1'b0;
      end
      cdq_pkg::CELL_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// ===== hdl/cdq_rear_pick.sv =====
// Registered two-level AND-OR tree that picks the rear cell's word.
module cdq_rear_pick #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  load_i,
  input  logic [DEPTH-1:0]                      last_i,
  input  logic [DEPTH-1:0][cdq_pkg::WORD_W-1:0] data_i,
  output logic [cdq_pkg::WORD_W-1:0]            value_o
);

  localparam int GRP  = cdq_pkg::PICK_GRP;
  localparam int NGRP = (DEPTH + GRP - 1) / GRP;

  logic [NGRP*GRP-1:0][cdq_pkg::WORD_W-1:0] masked;
  logic [NGRP-1:0][cdq_pkg::WORD_W-1:0]     grp_d, grp_q;

  for (genvar i = 0; i < NGRP*GRP; i++) begin : g_mask
    if (i < DEPTH) begin : g_real
      assign masked[i] = last_i[i] ? data_i[i] : '0;
    end else begin : g_pad
      assign masked[i] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        grp_d[g] = grp_d[g] | masked[g*GRP + k];
      end
    end
  end

  // Capture the first level only when a rear pop is taken.
  always_ff @(posedge clk_i) begin
    if (load_i) grp_q <= grp_d;
  end

  always_comb begin
    value_o = '0;
    for (int g = 0; g < NGRP; g++) begin
      value_o = value_o | grp_q[g];
    end
  end

endmodule

// ===== hdl/circular_deque.sv =====
// Circular deque: a row of shifting cells with occupancy and capacity control.
// Timing: push and front-pop responses go from the taken request into the output register;
//   a rear pop first latches the rear word into the registered pick tree, then answers from it.
// Throughput: one request per cycle while the skid stage is empty, except that a rear pop
//   holds off the input while its answer is read from the pick tree.
// Reset: deque empty (all cell valid bits cleared), capacity 64 clamped to DEPTH,
//   response channel empty; cell data is not reset.
module circular_deque #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdq_req_if.sink    req_i,
  cdq_rsp_if.source  rsp_o,
  cdq_cfg_if.sink    cfg_i
);

  localparam int OW      = $clog2(DEPTH + 1);
  localparam int CAP_RST = (DEPTH < cdq_pkg::CAP_RESET) ? DEPTH : cdq_pkg::CAP_RESET;

  // Control state.
  cdq_pkg::cdq_state_e   state_q, state_d;
  logic [OW-1:0]         occ_q, occ_d;
  logic [OW-1:0]         cap_q, cap_d;

  // Response register and skid stage.
  logic                          out_valid_q, out_valid_d;
  logic [cdq_pkg::WORD_W-1:0]    out_value_q, out_value_d;
  cdq_pkg::cdq_status_e          out_status_q, out_status_d;
  logic                          skid_valid_q, skid_valid_d;
  logic [cdq_pkg::WORD_W-1:0]    skid_value_q, skid_value_d;
  cdq_pkg::cdq_status_e          skid_status_q, skid_status_d;

  // Response produced this cycle.
  logic                          res_valid;
  logic [cdq_pkg::WORD_W-1:0]    res_value;
  cdq_pkg::cdq_status_e          res_status;

  logic                          accept;
  logic                          pick_load;
  cdq_pkg::cdq_mode_e            mode;
  cdq_pkg::cdq_cell_cmd_t        cmd;
  logic [OW-1:0]                 cap_new;

  logic [DEPTH-1:0]                          cell_valid;
  logic [DEPTH-1:0]                          cell_last;
  logic [DEPTH-1:0][cdq_pkg::WORD_W-1:0]     cell_data;
  logic [cdq_pkg::WORD_W-1:0]                rear_value;

  // Take a new request only when idle and the skid stage has room.
  assign req_i.ready = (state_q == cdq_pkg::S_IDLE) && !skid_valid_q;
  assign accept      = req_i.valid && req_i.ready;
  assign mode        = cdq_pkg::cdq_mode_e'(req_i.mode);
  assign cfg_i.ready = 1'b1;

  // Clamp the written capacity into 1..DEPTH.
  always_comb begin
    if (cfg_i.capacity_in_use == '0) begin
      cap_new = OW'(1);
    end else if (int'(cfg_i.capacity_in_use) > DEPTH) begin
      cap_new = OW'(DEPTH);
    end else begin
      cap_new = OW'(cfg_i.capacity_in_use);
    end
  end

  // Request decode: drive the cell row, track occupancy, form the response.
  always_comb begin
    state_d    = state_q;
    occ_d      = occ_q;
    cap_d      = cap_q;
    cmd.op     = cdq_pkg::CELL_HOLD;
    cmd.value  = req_i.push_value;
    pick_load  = 1'b0;
    res_valid  = 1'b0;
    res_value  = '0;
    res_status = cdq_pkg::STAT_DONE;

    case (state_q)
      cdq_pkg::S_IDLE: begin
        if (accept) begin
          res_valid = 1'b1;
          case (mode)
            cdq_pkg::MODE_PUSH_FRONT: begin
              if (occ_q >= cap_q) begin
                res_status = cdq_pkg::STAT_FULL;
              end else begin
                cmd.op = cdq_pkg::CELL_SHIFT_IN;
                occ_d  = occ_q + OW'(1);
              end
            end
            cdq_pkg::MODE_PUSH_REAR: begin
              if (occ_q >= cap_q) begin
                res_status = cdq_pkg::STAT_FULL;
              end else begin
                cmd.op = cdq_pkg::CELL_APPEND;
                occ_d  = occ_q + OW'(1);
              end
            end
            cdq_pkg::MODE_POP_FRONT: begin
              if (occ_q == '0) begin
                res_status = cdq_pkg::STAT_EMPTY;
              end else begin
                // Front word sits in the first cell; shift the row toward it.
                cmd.op    = cdq_pkg::CELL_SHIFT_OUT;
                res_value = cell_data[0];
                occ_d     = occ_q - OW'(1);
              end
            end
            cdq_pkg::MODE_POP_REAR: begin
              if (occ_q == '0) begin
                res_status = cdq_pkg::STAT_EMPTY;
              end else begin
                // Latch the rear word into the pick tree and drop the cell.
                cmd.op    = cdq_pkg::CELL_DROP_REAR;
                pick_load = 1'b1;
                res_valid = 1'b0;
                occ_d     = occ_q - OW'(1);
                state_d   = cdq_pkg::S_REAR;
              end
            end
            default: begin
              res_status = cdq_pkg::STAT_DONE;
            end
          endcase
        end
      end
      cdq_pkg::S_REAR: begin
        res_valid = 1'b1;
        res_value = rear_value;
        state_d   = cdq_pkg::S_IDLE;
      end
      default: begin
        state_d = cdq_pkg::S_IDLE;
      end
    endcase

    // A capacity write empties the deque.
    if (cfg_i.valid) begin
      cap_d  = cap_new;
      occ_d  = '0;
      cmd.op = cdq_pkg::CELL_CLEAR;
    end
  end

  // Response path: output register backed by one skid entry.
  always_comb begin
    out_valid_d   = out_valid_q;
    out_value_d   = out_value_q;
    out_status_d  = out_status_q;
    skid_valid_d  = skid_valid_q;
    skid_value_d  = skid_value_q;
    skid_status_d = skid_status_q;
    if (!out_valid_q || rsp_o.ready) begin
      if (skid_valid_q) begin
        out_valid_d   = 1'b1;
        out_value_d   = skid_value_q;
        out_status_d  = skid_status_q;
        skid_valid_d  = res_valid;
        skid_value_d  = res_value;
        skid_status_d = res_status;
      end else begin
        out_valid_d  = res_valid;
        out_value_d  = res_value;
        out_status_d = res_status;
      end
    end else if (res_valid) begin
      skid_valid_d  = 1'b1;
      skid_value_d  = res_value;
      skid_status_d = res_status;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.pop_value = out_value_q;
  assign rsp_o.status    = out_status_q;

  // Cell row: the first cell's left neighbor is the incoming value, always valid.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                       lv, rv;
    logic [cdq_pkg::WORD_W-1:0] ld, rd;
    if (i == 0) begin : g_first
      assign lv = 1'b1;
      assign ld = cmd.value;
    end else begin : g_mid_l
      assign lv = cell_valid[i-1];
      assign ld = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_mid_r
      assign rv = cell_valid[i+1];
      assign rd = cell_data[i+1];
    end
    cdq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .left_valid_i  (lv),
      .left_data_i   (ld),
      .right_valid_i (rv),
      .right_data_i  (rd),
      .valid_o       (cell_valid[i]),
      .last_o        (cell_last[i]),
      .data_o        (cell_data[i])
    );
  end

  cdq_rear_pick #(
    .DEPTH (DEPTH)
  ) u_rear_pick (
    .clk_i   (clk_i),
    .load_i  (pick_load),
    .last_i  (cell_last),
    .data_i  (cell_data),
    .value_o (rear_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cdq_pkg::S_IDLE;
      occ_q        <= '0;
      cap_q        <= OW'(CAP_RST);
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      occ_q        <= occ_d;
      cap_q        <= cap_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q   <= out_value_d;
    out_status_q  <= out_status_d;
    skid_value_q  <= skid_value_d;
    skid_status_q <= skid_status_d;
  end

  // Occupancy must match the number of valid cells.
  a_occ_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(occ_q))
    else $error("occupancy disagrees with cell row");

  a_occ_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= cap_q)
    else $error("occupancy above capacity");

  a_rear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cdq_pkg::S_REAR |=> state_q == cdq_pkg::S_IDLE)
    else $error("rear pop did not finish");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a response ahead of an empty output");

endmodule
